### src/gif_lzw_decoder_assert.svh
// assertion macros shared by the checker
// no dependencies
`ifndef GIF_LZW_DECODER_ASSERT_SVH
`define GIF_LZW_DECODER_ASSERT_SVH
`define GLD_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("implication failed");
`define GLD_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("next-cycle check failed");
`endif

### src/gld_pkg.sv
// shared types and constants of the gif lzw decoder
// no dependencies
package gld_pkg;
  localparam int unsigned CodeClear = 256;
  localparam int unsigned CodeEnd   = 257;
  localparam int unsigned CodeFirst = 258;
  localparam int unsigned WidthMin  = 9;

  typedef enum logic [0:0] {
    OP_PUSH = 1'b0,
    OP_PULL = 1'b1
  } op_e;

  localparam logic [0:0] RegImageWidth = 1'b0;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic        byte_accepted;
    logic        pixel_valid;
    logic [7:0]  pixel_index;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic        need_data;
    logic        finished;
    logic        bad_code;
  } result_t;
endpackage

### src/gif_lzw_decoder.sv
// GIF LZW decoder: a push takes one stream byte (length bytes included) and
// gives one word; a pull that pops the reversal stack reads it and gives a pixel,
// as does a pull that takes the first code after a clear; one that finds a clear
// code, an end code, too few bits or a finished stream gives its word from the
// idle state, and any other pull that decodes a code walks the table (one table
// read per step, on its read port), writes the new entry, then pops the stack.
// Results wait in an output register while a two-entry input queue takes more.
module gif_lzw_decoder #(
  parameter int unsigned MaxCodeBits = 12,
  parameter int unsigned StackDepth  = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        operation_i,
  input  logic [7:0]  data_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic        byte_accepted_o,
  output logic        pixel_valid_o,
  output logic [7:0]  pixel_index_o,
  output logic [15:0] pixel_x_o,
  output logic [15:0] pixel_y_o,
  output logic        need_data_o,
  output logic        finished_o,
  output logic        bad_code_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gld_pkg::*;

  logic [15:0] width_q;
  item_t       in_item, q_item;
  logic        q_valid, q_take;
  result_t     res;

  assign pready = 1'b1;
  assign prdata = (paddr == {RegImageWidth, 1'b0}) ? {16'd0, width_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) width_q <= 16'd1;
    else if (psel && penable && pwrite && paddr == {RegImageWidth, 1'b0})
      width_q <= pwdata[15:0];
  end

  assign in_item = '{op: operation_i, data: data_byte_i};

  gld_front u_front (
    .clk_i, .rst_ni, .push_i(push), .item_i(in_item), .full_o(full),
    .valid_o(q_valid), .item_o(q_item), .take_i(q_take)
  );

  gld_back #(.MaxCodeBits(MaxCodeBits), .StackDepth(StackDepth)) u_back (
    .clk_i, .rst_ni, .line_len_i(width_q), .valid_i(q_valid), .item_i(q_item),
    .take_o(q_take), .empty_o(empty), .res_o(res), .pop_i(pop)
  );

  assign byte_accepted_o = res.byte_accepted;
  assign pixel_valid_o   = res.pixel_valid;
  assign pixel_index_o   = res.pixel_index;
  assign pixel_x_o       = res.pixel_x;
  assign pixel_y_o       = res.pixel_y;
  assign need_data_o     = res.need_data;
  assign finished_o      = res.finished;
  assign bad_code_o      = res.bad_code;
endmodule

### src/gld_front.sv
// front part: accepts items into a two-entry queue
// depends on gld_pkg
module gld_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  gld_pkg::item_t item_i,
  output logic           full_o,
  output logic           valid_o,
  output gld_pkg::item_t item_o,
  input  logic           take_i
);
  import gld_pkg::*;

  item_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       wr_en, rd_en;

  assign full_o  = cnt_q[1];
  assign valid_o = cnt_q != 2'd0;
  assign item_o  = mem_q[rd_q];
  assign wr_en   = push_i && !full_o;
  assign rd_en   = take_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr_en) wr_q <= ~wr_q;
      if (rd_en) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end
endmodule

### src/gld_back.sv
// back part: bit buffer, lzw table walk, reversal stack, result output register
// depends on gld_pkg
module gld_back #(
  parameter int unsigned MaxCodeBits = 12,
  parameter int unsigned StackDepth  = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [15:0]      line_len_i,
  input  logic             valid_i,
  input  gld_pkg::item_t   item_i,
  output logic             take_o,
  output logic             empty_o,
  output gld_pkg::result_t res_o,
  input  logic             pop_i
);
  import gld_pkg::*;

  localparam int unsigned TableSize = 1 << MaxCodeBits;
  localparam int unsigned SW = $clog2(StackDepth);
  localparam int unsigned LW = SW + 1;
  localparam int unsigned CW = MaxCodeBits;

  typedef enum logic [2:0] {
    ST_IDLE, ST_WALK_RD, ST_WALK, ST_FINISH, ST_POP_RD, ST_POP
  } state_e;

  typedef enum logic [1:0] {PH_FIRST, PH_RUN, PH_DONE} phase_e;

  logic [19:0]   table_mem [TableSize];
  logic [7:0]    stack_mem [StackDepth];
  logic [19:0]   tab_rd_q;
  logic [7:0]    stk_rd_q;

  state_e        state_q;
  phase_e        phase_q;
  logic [LW-1:0] level_q;
  logic [23:0]   buf_q;
  logic [4:0]    held_q;
  logic [7:0]    left_q;
  logic [3:0]    width_q;
  logic [CW:0]   nfree_q;
  logic [CW-1:0] prev_q, code_q, p_q;
  logic [7:0]    lfc_q;
  logic [15:0]   col_q, row_q;
  logic          closed_q, sbad_q, walk_bad_q, out_full_q;
  result_t       out_q;

  logic [CW-1:0] code_w;
  logic [15:0]   col_inc;
  logic          stk_we;
  logic [SW-1:0] stk_wa;
  logic [7:0]    stk_wd;
  logic          push_ok, out_set;

  assign empty_o = !out_full_q;
  assign res_o   = out_q;
  assign take_o  = (state_q == ST_IDLE) && valid_i && (!out_full_q || pop_i);
  assign code_w  = CW'(buf_q & ((24'd1 << width_q) - 24'd1));
  assign col_inc = col_q + 16'd1;
  assign push_ok = !(closed_q || phase_q == PH_DONE) && (left_q == 8'd0 || held_q <= 5'd16);

  // a word is ready once an item finishes: a push, a stack pop, or a pull needing no pop
  always_comb begin
    out_set = 1'b0;
    if (state_q == ST_POP) begin
      out_set = 1'b1;
    end else if (take_o) begin
      if (item_i.op == OP_PUSH) out_set = 1'b1;
      else if (level_q != '0) out_set = 1'b0;
      else if (phase_q == PH_DONE) out_set = 1'b1;
      else if (held_q > 5'(width_q))
        out_set = (32'(code_w) == CodeClear) || (32'(code_w) == CodeEnd);
      else out_set = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stack_mem[stk_wa] <= stk_wd;
    stk_rd_q <= stack_mem[SW'(level_q - LW'(1))];
    tab_rd_q <= table_mem[p_q];
    if (state_q == ST_FINISH && nfree_q < (CW+1)'(TableSize))
      table_mem[nfree_q[CW-1:0]] <= {12'(prev_q), (p_q >= CW'(CodeClear)) ? 8'd0 : p_q[7:0]};
  end

  // stack write port, driven by the state machine
  always_comb begin
    stk_we = 1'b0;
    stk_wa = level_q[SW-1:0];
    stk_wd = 8'd0;
    if (level_q < LW'(StackDepth)) begin
      if (state_q == ST_WALK) begin
        stk_we = !(p_q < CW'(CodeFirst) || (CW+1)'(p_q) >= nfree_q ||
                   level_q >= LW'(StackDepth - 1));
        stk_wd = tab_rd_q[7:0];
      end else if (state_q == ST_FINISH) begin
        stk_we = 1'b1;
        stk_wd = (p_q >= CW'(CodeClear) || walk_bad_q) ? 8'd0 : p_q[7:0];
      end else if (state_q == ST_IDLE && take_o && item_i.op == OP_PULL &&
                   level_q == '0 && phase_q != PH_DONE && held_q > 5'(width_q) &&
                   32'(code_w) != CodeClear && 32'(code_w) != CodeEnd) begin
        stk_we = 1'b1;
        if (phase_q == PH_FIRST) stk_wd = (32'(code_w) < CodeClear) ? code_w[7:0] : 8'd0;
        else stk_wd = lfc_q;
        stk_we = (phase_q == PH_FIRST) || (CW+1)'(code_w) >= nfree_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; phase_q <= PH_FIRST; level_q <= '0; buf_q <= '0;
      held_q <= '0; left_q <= '0; width_q <= 4'(WidthMin);
      nfree_q <= (CW+1)'(CodeFirst); prev_q <= '0; code_q <= '0; p_q <= '0;
      lfc_q <= '0; col_q <= '0; row_q <= '0; closed_q <= 1'b0; sbad_q <= 1'b0;
      walk_bad_q <= 1'b0; out_full_q <= 1'b0; out_q <= '0;
    end else begin
      if (out_set) out_full_q <= 1'b1;
      else if (pop_i && out_full_q) out_full_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (take_o) begin
            if (item_i.op == OP_PUSH) begin
              out_q <= result_t'{byte_accepted: push_ok, default: '0};
              if (push_ok) begin
                if (left_q == 8'd0) begin
                  if (item_i.data == 8'd0) closed_q <= 1'b1;
                  else left_q <= item_i.data;
                end else begin
                  buf_q <= buf_q | (24'(item_i.data) << held_q);
                  held_q <= held_q + 5'd8;
                  left_q <= left_q - 8'd1;
                end
              end
            end else if (level_q != '0) begin
              state_q <= ST_POP_RD;
            end else if (phase_q == PH_DONE) begin
              out_q <= result_t'{finished: 1'b1, default: '0};
            end else if (held_q > 5'(width_q)) begin
              buf_q  <= buf_q >> width_q;
              held_q <= held_q - 5'(width_q);
              code_q <= code_w;
              if (32'(code_w) == CodeClear) begin
                width_q <= 4'(WidthMin); nfree_q <= (CW+1)'(CodeFirst);
                phase_q <= PH_FIRST; out_q <= '0;
              end else if (32'(code_w) == CodeEnd) begin
                phase_q <= PH_DONE; out_q <= result_t'{finished: 1'b1, default: '0};
              end else if (phase_q == PH_FIRST) begin
                lfc_q  <= (32'(code_w) < CodeClear) ? code_w[7:0] : 8'd0;
                sbad_q <= 32'(code_w) >= CodeClear;
                prev_q <= code_w; phase_q <= PH_RUN;
                level_q <= LW'(1); state_q <= ST_POP_RD;
              end else begin
                walk_bad_q <= 1'b0;
                if ((CW+1)'(code_w) >= nfree_q) begin
                  level_q <= LW'(1); p_q <= prev_q;
                end else begin
                  level_q <= '0; p_q <= code_w;
                end
                state_q <= ST_WALK_RD;
              end
            end else if (closed_q) begin
              phase_q <= PH_DONE; out_q <= result_t'{finished: 1'b1, default: '0};
            end else begin
              out_q <= result_t'{need_data: 1'b1, default: '0};
            end
          end
        end
        ST_WALK_RD: begin
          // one table read per step
          if (32'(p_q) >= CodeClear) state_q <= ST_WALK;
          else state_q <= ST_FINISH;
        end
        ST_WALK: begin
          if (p_q < CW'(CodeFirst) || (CW+1)'(p_q) >= nfree_q ||
              level_q >= LW'(StackDepth - 1)) begin
            walk_bad_q <= 1'b1; p_q <= '0; state_q <= ST_FINISH;
          end else begin
            if (level_q < LW'(StackDepth)) level_q <= level_q + LW'(1);
            p_q <= CW'(tab_rd_q[19:8]);
            state_q <= ST_WALK_RD;
          end
        end
        ST_FINISH: begin
          if (level_q < LW'(StackDepth)) level_q <= level_q + LW'(1);
          lfc_q  <= p_q[7:0];
          sbad_q <= walk_bad_q;
          if (nfree_q < (CW+1)'(TableSize)) begin
            nfree_q <= nfree_q + (CW+1)'(1);
            if (32'(nfree_q) + 1 > (1 << width_q) - 1 && 32'(width_q) < MaxCodeBits)
              width_q <= width_q + 4'd1;
          end
          prev_q <= code_q;
          state_q <= ST_POP_RD;
        end
        ST_POP_RD: state_q <= ST_POP;
        ST_POP: begin
          level_q <= level_q - LW'(1);
          out_q <= result_t'{pixel_valid: 1'b1, pixel_index: stk_rd_q, pixel_x: col_q,
                             pixel_y: row_q, bad_code: sbad_q, default: '0};
          if (col_inc >= line_len_i) begin
            col_q <= '0; row_q <= row_q + 16'd1;
          end else col_q <= col_inc;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end
endmodule

### src/gld_checker.sv
// port-level checks of the gif lzw decoder, bound to the top level
// depends on gif_lzw_decoder_assert.svh
`include "gif_lzw_decoder_assert.svh"
module gld_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic        byte_accepted_o,
  input logic        pixel_valid_o,
  input logic        need_data_o,
  input logic        finished_o,
  input logic        pready
);
  `GLD_ASSERT_IMP(a_one_kind, clk_i, rst_ni, !empty, !(byte_accepted_o && pixel_valid_o))
  `GLD_ASSERT_IMP(a_pix_excl, clk_i, rst_ni, !empty && pixel_valid_o, !need_data_o && !finished_o)
  `GLD_ASSERT_NXT(a_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(pixel_valid_o))
  `GLD_ASSERT_IMP(a_ready, clk_i, rst_ni, 1'b1, pready)
endmodule

bind gif_lzw_decoder gld_checker u_gld_checker (.*);
